### sv/point_in_triangle_barycentric_defines.svh
`ifndef POINT_IN_TRIANGLE_BARYCENTRIC_DEFINES_SVH
`define POINT_IN_TRIANGLE_BARYCENTRIC_DEFINES_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define PTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that only applies while a result beat is on the ports.
`define PTB_ASSERT_BEAT(label, cond, msg) \
  `PTB_ASSERT(label, valid_o |-> (cond), msg)

`endif

### sv/ptb_pkg.sv
`default_nettype none
package ptb_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 28;
  localparam int unsigned OUT_WIDTH       = 32;
  localparam int unsigned FRONT_STAGES    = 5;
  // front stages, one divider cell per quotient bit, output register
  localparam int unsigned PIPE_LAT        = FRONT_STAGES + OUT_WIDTH + 1;

  typedef struct packed {
    logic in_tri;
    logic degen;
    logic neg_u;
    logic neg_v;
  } ptb_flags_t;

endpackage
`default_nettype wire

### sv/ptb_front.sv
`default_nettype none
module ptb_front import ptb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned DW          = 2 * COORD_WIDTH + 4,
  parameter int unsigned PW          = 2 * DW,
  parameter int unsigned NW          = PW + 1,
  parameter int unsigned RW          = NW + OUT_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_i [3],
  input  wire logic signed [COORD_WIDTH-1:0] b_i [3],
  input  wire logic signed [COORD_WIDTH-1:0] c_i [3],
  input  wire logic signed [COORD_WIDTH-1:0] p_i [3],
  output logic                               vld_o,
  output ptb_flags_t                         flags_o,
  output logic [RW-1:0]                      rem_u_o,
  output logic [RW-1:0]                      rem_v_o,
  output logic [NW-2:0]                      den_o
);

  function automatic logic signed [DW-1:0] dot(input logic signed [COORD_WIDTH:0] x [3],
                                               input logic signed [COORD_WIDTH:0] y [3]);
    logic signed [2*COORD_WIDTH+1:0] p;
    logic signed [DW-1:0]            acc;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      p   = x[k] * y[k];
      acc = acc + DW'(p);
    end
    return acc;
  endfunction

  logic [FRONT_STAGES-1:0] vld_q;

  // stage 1: edge vectors
  logic signed [COORD_WIDTH:0] e1_q [3], e2_q [3], w_q [3];
  // stage 2: dot products
  logic signed [DW-1:0] d11_q, d12_q, d22_q, d1w_q, d2w_q;
  // stage 3: cross products of dot products
  logic signed [PW-1:0] p_dd_q, p_12_q, p_a_q, p_b_q, p_c_q, p_d_q;
  // stage 4: determinant and numerators
  logic signed [NW-1:0] den_q, nu_q, nv_q;
  // stage 5
  ptb_flags_t           flags_q;
  logic [RW-1:0]        rem_u_q, rem_v_q;
  logic [NW-2:0]        den5_q;

  logic signed [NW:0]   sum_d;
  logic [NW-1:0]        mag_u_d, mag_v_d;
  ptb_flags_t           flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], vld_i};
    end
  end

  always_comb begin
    sum_d   = {nu_q[NW-1], nu_q} + {nv_q[NW-1], nv_q};
    mag_u_d = nu_q[NW-1] ? NW'(-nu_q) : nu_q;
    mag_v_d = nv_q[NW-1] ? NW'(-nv_q) : nv_q;
    flags_d.degen  = (den_q == '0) || den_q[NW-1];
    flags_d.in_tri = !flags_d.degen && !nu_q[NW-1] && !nv_q[NW-1] &&
                     (sum_d <= {den_q[NW-1], den_q});
    flags_d.neg_u  = nu_q[NW-1];
    flags_d.neg_v  = nv_q[NW-1];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e1_q[k] <= {b_i[k][COORD_WIDTH-1], b_i[k]} - {a_i[k][COORD_WIDTH-1], a_i[k]};
      e2_q[k] <= {c_i[k][COORD_WIDTH-1], c_i[k]} - {a_i[k][COORD_WIDTH-1], a_i[k]};
      w_q[k]  <= {p_i[k][COORD_WIDTH-1], p_i[k]} - {a_i[k][COORD_WIDTH-1], a_i[k]};
    end
    d11_q  <= dot(e1_q, e1_q);
    d12_q  <= dot(e1_q, e2_q);
    d22_q  <= dot(e2_q, e2_q);
    d1w_q  <= dot(e1_q, w_q);
    d2w_q  <= dot(e2_q, w_q);
    p_dd_q <= d22_q * d11_q;
    p_12_q <= d12_q * d12_q;
    p_a_q  <= d11_q * d2w_q;
    p_b_q  <= d12_q * d1w_q;
    p_c_q  <= d22_q * d1w_q;
    p_d_q  <= d12_q * d2w_q;
    den_q  <= {p_dd_q[PW-1], p_dd_q} - {p_12_q[PW-1], p_12_q};
    nu_q   <= {p_a_q[PW-1], p_a_q} - {p_b_q[PW-1], p_b_q};
    nv_q   <= {p_c_q[PW-1], p_c_q} - {p_d_q[PW-1], p_d_q};
    flags_q <= flags_d;
    rem_u_q <= RW'(mag_u_d) << FRAC_BITS;
    rem_v_q <= RW'(mag_v_d) << FRAC_BITS;
    den5_q  <= den_q[NW-2:0];
  end

  assign vld_o   = vld_q[FRONT_STAGES-1];
  assign flags_o = flags_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign den_o   = den5_q;

endmodule
`default_nettype wire

### sv/ptb_div_cell.sv
`default_nettype none
module ptb_div_cell import ptb_pkg::*; #(
  parameter int unsigned RW    = 105,
  parameter int unsigned DENW  = 72,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 vld_i,
  input  wire ptb_flags_t           flags_i,
  input  wire logic [RW-1:0]        rem_u_i,
  input  wire logic [RW-1:0]        rem_v_i,
  input  wire logic [DENW-1:0]      den_i,
  input  wire logic [OUT_WIDTH-1:0] q_u_i,
  input  wire logic [OUT_WIDTH-1:0] q_v_i,
  output logic                      vld_o,
  output ptb_flags_t                flags_o,
  output logic [RW-1:0]             rem_u_o,
  output logic [RW-1:0]             rem_v_o,
  output logic [DENW-1:0]           den_o,
  output logic [OUT_WIDTH-1:0]      q_u_o,
  output logic [OUT_WIDTH-1:0]      q_v_o
);

  logic [RW-1:0]        trial;
  logic                 ge_u, ge_v;
  logic [RW-1:0]        rem_u_d, rem_v_d;
  logic [OUT_WIDTH-1:0] q_u_d, q_v_d;
  logic                 vld_q;

  // subtract the shifted divisor where it fits, set one quotient bit
  always_comb begin
    trial   = RW'(den_i) << SHIFT;
    ge_u    = rem_u_i >= trial;
    ge_v    = rem_v_i >= trial;
    rem_u_d = ge_u ? rem_u_i - trial : rem_u_i;
    rem_v_d = ge_v ? rem_v_i - trial : rem_v_i;
    q_u_d        = q_u_i;
    q_u_d[SHIFT] = ge_u;
    q_v_d        = q_v_i;
    q_v_d[SHIFT] = ge_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_o <= flags_i;
    rem_u_o <= rem_u_d;
    rem_v_o <= rem_v_d;
    den_o   <= den_i;
    q_u_o   <= q_u_d;
    q_v_o   <= q_v_d;
  end

  assign vld_o = vld_q;

endmodule
`default_nettype wire

### sv/point_in_triangle_barycentric.sv
// Barycentric point-in-triangle test. Assert start_i with A, B, C and P on the
// coordinate ports; busy_o is always low, so a new item is taken every cycle.
// Each item yields one result beat on valid_o after five front stages (edges,
// dot products, products, numerators, then flags and scaled remainders), one
// divider cell per quotient bit for the 32 bits and one output register; the
// latency is set by the bit-per-cell divider chain. Results come out in order
// and cannot be stalled: the receiver must take valid_o beats as they appear.
// u and v are signed Q4.28 by default, saturated; a degenerate triangle gives
// u = v = 0, inside_res_o = 0 and degenerate_o = 1.
`default_nettype none
module point_in_triangle_barycentric import ptb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] c_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] c_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] c_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] p_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] p_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] p_z_i,
  output logic                               valid_o,
  output logic                               inside_res_o,
  output logic                               degenerate_o,
  output logic signed [OUT_WIDTH-1:0]        coord_u_o,
  output logic signed [OUT_WIDTH-1:0]        coord_v_o
);

  localparam int unsigned DW   = 2 * COORD_WIDTH + 4;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned NW   = PW + 1;
  localparam int unsigned RW   = NW + OUT_WIDTH;
  localparam int unsigned DENW = NW - 1;

  logic signed [COORD_WIDTH-1:0] a_vec [3], b_vec [3], c_vec [3], p_vec [3];

  logic                 vld   [OUT_WIDTH+1];
  ptb_flags_t           flags [OUT_WIDTH+1];
  logic [RW-1:0]        rem_u [OUT_WIDTH+1];
  logic [RW-1:0]        rem_v [OUT_WIDTH+1];
  logic [DENW-1:0]      den   [OUT_WIDTH+1];
  logic [OUT_WIDTH-1:0] q_u   [OUT_WIDTH+1];
  logic [OUT_WIDTH-1:0] q_v   [OUT_WIDTH+1];

  logic                        valid_q;
  logic                        inside_q, degen_q;
  logic signed [OUT_WIDTH-1:0] u_q, v_q, u_d, v_d;
  ptb_flags_t                  fl;
  logic [OUT_WIDTH-1:0]        qu, qv;

  assign a_vec = '{a_x_i, a_y_i, a_z_i};
  assign b_vec = '{b_x_i, b_y_i, b_z_i};
  assign c_vec = '{c_x_i, c_y_i, c_z_i};
  assign p_vec = '{p_x_i, p_y_i, p_z_i};

  assign busy_o = 1'b0;

  ptb_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .DW         (DW),
    .PW         (PW),
    .NW         (NW),
    .RW         (RW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i && !busy_o),
    .a_i    (a_vec),
    .b_i    (b_vec),
    .c_i    (c_vec),
    .p_i    (p_vec),
    .vld_o  (vld[0]),
    .flags_o(flags[0]),
    .rem_u_o(rem_u[0]),
    .rem_v_o(rem_v[0]),
    .den_o  (den[0])
  );

  assign q_u[0] = '0;
  assign q_v[0] = '0;

  // top cell tests the saturation bit, the rest produce the quotient
  for (genvar i = 0; i < OUT_WIDTH; i++) begin : g_cell
    ptb_div_cell #(
      .RW   (RW),
      .DENW (DENW),
      .SHIFT(OUT_WIDTH - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .flags_i(flags[i]),
      .rem_u_i(rem_u[i]),
      .rem_v_i(rem_v[i]),
      .den_i  (den[i]),
      .q_u_i  (q_u[i]),
      .q_v_i  (q_v[i]),
      .vld_o  (vld[i+1]),
      .flags_o(flags[i+1]),
      .rem_u_o(rem_u[i+1]),
      .rem_v_o(rem_v[i+1]),
      .den_o  (den[i+1]),
      .q_u_o  (q_u[i+1]),
      .q_v_o  (q_v[i+1])
    );
  end

  always_comb begin
    fl = flags[OUT_WIDTH];
    qu = q_u[OUT_WIDTH];
    qv = q_v[OUT_WIDTH];
    if (qu[OUT_WIDTH-1]) begin
      u_d = fl.neg_u ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end else begin
      u_d = fl.neg_u ? -qu : qu;
    end
    if (qv[OUT_WIDTH-1]) begin
      v_d = fl.neg_v ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end else begin
      v_d = fl.neg_v ? -qv : qv;
    end
    if (fl.degen) begin
      u_d = '0;
      v_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld[OUT_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= fl.in_tri;
    degen_q  <= fl.degen;
    u_q      <= u_d;
    v_q      <= v_d;
  end

  assign valid_o      = valid_q;
  assign inside_res_o = inside_q;
  assign degenerate_o = degen_q;
  assign coord_u_o    = u_q;
  assign coord_v_o    = v_q;

endmodule
`default_nettype wire

### sv/ptb_checker.sv
`default_nettype none
`include "point_in_triangle_barycentric_defines.svh"
module ptb_checker import ptb_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start_i,
  input wire logic                 busy_o,
  input wire logic                 valid_o,
  input wire logic                 inside_res_o,
  input wire logic                 degenerate_o,
  input wire logic [OUT_WIDTH-1:0] coord_u_o,
  input wire logic [OUT_WIDTH-1:0] coord_v_o
);

  `PTB_ASSERT(a_never_busy, !busy_o, "busy_o raised on a fully pipelined block")
  `PTB_ASSERT(a_fixed_latency, valid_o == $past(start_i && !busy_o && rst_ni, PIPE_LAT), "result beat does not follow its start by the pipeline latency")
  `PTB_ASSERT_BEAT(a_degen_outside, !(degenerate_o && inside_res_o), "degenerate triangle reported inside")
  `PTB_ASSERT_BEAT(a_degen_zero, !degenerate_o || (coord_u_o == '0 && coord_v_o == '0), "degenerate triangle with nonzero coordinates")

endmodule

bind point_in_triangle_barycentric ptb_checker u_ptb_checker (.*);
`default_nettype wire
